### rtl/lpkm_pkg.sv
package lpkm_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned CTX_W  = 16;
  localparam int unsigned HOME_W = 16;

  localparam logic [KEY_W-1:0] MIX_MULT  = 64'hff51afd7ed558ccd;
  localparam int unsigned      MIX_SHIFT = 33;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_HIT       = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_MISS      = 3'd4
  } status_e;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [CTX_W-1:0]  ctx;
    logic              flag;
    logic              zero_key;
    logic [HOME_W-1:0] home;
  } item_t;

  typedef struct packed {
    logic             used;
    logic             flag;
    logic [CTX_W-1:0] ctx;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

### rtl/linear_probe_key_map_unit.sv
// Flow: a nonzero key is hashed, then slots are probed in turn and the result is
//   handed off; a zero key skips hashing and probing.
// Throughput: the input waits for each item's hash on the shared 32x32 multiplier;
//   the probe engine serves one item at a time, bound by the single slot memory port.
// Reset: async active low; a clearing pass then marks every slot empty, with no input
//   transfer accepted until it ends.
module linear_probe_key_map_unit #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // key[63:0], context_in[79:64], flag_in[80], zero pad
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // context_out[15:0], flag_out[16], zero pad
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import lpkm_pkg::*;

  logic        clear_busy;
  logic        push_valid;
  logic        push_ready;
  item_t       push_item;
  logic        pop_valid;
  logic        pop_ready;
  item_t       pop_item;
  status_e     out_status;
  logic [15:0] out_ctx;
  logic        out_flag;

  lpkm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_i (clear_busy),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  lpkm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  lpkm_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_o (clear_busy),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_ctx_o    (out_ctx),
    .out_flag_o   (out_flag)
  );

  assign m_axis_tdata = {7'h0, out_flag, out_ctx};
  assign m_axis_tuser = out_status;

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clear_busy |-> !s_axis_tready
  ) else $error("input accepted during slot clearing pass");

  a_payload_zero_unless_hit : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && (m_axis_tuser != ST_HIT)) |-> (m_axis_tdata == '0)
  ) else $error("nonzero context or flag on a result other than a hit");

  a_status_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_HIT ||
                         m_axis_tuser == ST_DUPLICATE || m_axis_tuser == ST_FULL ||
                         m_axis_tuser == ST_MISS)
  ) else $error("result status code out of range");

  a_no_pop_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clear_busy |-> !pop_ready
  ) else $error("probe engine took an item during slot clearing pass");

endmodule

### rtl/lpkm_front.sv
module lpkm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_busy_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [87:0]         in_data_i,  // key[63:0], context_in[79:64], flag_in[80], zero pad
  input  logic [0:0]          in_user_i,  // action[0]
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lpkm_pkg::item_t     push_item_o
);
  import lpkm_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  front_state_e     state_q;
  logic [1:0]       step_q;
  logic             act_q;
  logic [KEY_W-1:0] key_q;
  logic [CTX_W-1:0] ctx_q;
  logic             flag_q;
  logic             zero_q;
  logic [KEY_W-1:0] a_q;
  logic [KEY_W-1:0] prod_q;
  logic [KEY_W-1:0] acc_q;

  logic [31:0]      op_a;
  logic [31:0]      op_m;
  logic [KEY_W-1:0] mul;
  logic [KEY_W-1:0] in_key;

  assign in_key = in_data_i[63:0];
  assign op_a   = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign op_m   = (step_q == 2'd1) ? MIX_MULT[63:32] : MIX_MULT[31:0];
  assign mul    = {32'h0, op_a} * {32'h0, op_m};

  assign in_ready_o   = (state_q == F_IDLE) && !clear_busy_i;
  assign push_valid_o = (state_q == F_PUSH);

  always_comb begin
    push_item_o.action   = act_q;
    push_item_o.key      = key_q;
    push_item_o.ctx      = ctx_q;
    push_item_o.flag     = flag_q;
    push_item_o.zero_key = zero_q;
    push_item_o.home     = acc_q[HOME_W-1:0] ^ acc_q[MIX_SHIFT +: HOME_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            act_q   <= in_user_i[0];
            key_q   <= in_key;
            ctx_q   <= in_data_i[79:64];
            flag_q  <= in_data_i[80];
            zero_q  <= (in_key == '0);
            a_q     <= in_key ^ (in_key >> MIX_SHIFT);
            acc_q   <= '0;
            step_q  <= 2'd0;
            state_q <= (in_key == '0) ? F_PUSH : F_MUL;
          end
        end
        F_MUL: begin
          prod_q <= mul;
          case (step_q) inside
            2'd1:       acc_q <= prod_q;
            2'd2, 2'd3: acc_q <= acc_q + {prod_q[31:0], 32'h0};
            default:    acc_q <= acc_q;
          endcase
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/lpkm_queue.sv
module lpkm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lpkm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lpkm_pkg::item_t pop_item_o
);
  import lpkm_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### rtl/lpkm_back.sv
module lpkm_back #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                clear_busy_o,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  lpkm_pkg::item_t     pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpkm_pkg::status_e   out_status_o,
  output logic [15:0]         out_ctx_o,
  output logic                out_flag_o
);
  import lpkm_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SLOTS);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_WAIT
  } back_state_e;

  back_state_e      state_q;
  item_t            cur_q;
  logic [IW-1:0]    addr_q;
  logic [IW-1:0]    probe_q;
  slot_t            rd_q;
  status_e          res_status_q;
  logic [CTX_W-1:0] res_ctx_q;
  logic             res_flag_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [CTX_W-1:0] out_ctx_q;
  logic             out_flag_q;

  slot_t            mem [TABLE_SLOTS];
  logic             wr_en;
  slot_t            wr_data;
  logic             match;

  assign clear_busy_o = (state_q == B_CLEAR);
  assign pop_ready_o  = (state_q == B_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_ctx_o    = out_ctx_q;
  assign out_flag_o   = out_flag_q;

  assign match = rd_q.used && (rd_q.key == cur_q.key);

  always_comb begin
    wr_en        = (state_q == B_CLEAR) ||
                   ((state_q == B_CHECK) && (cur_q.action == ACT_INSERT) && !rd_q.used);
    wr_data.used = (state_q != B_CLEAR);
    wr_data.flag = cur_q.flag;
    wr_data.ctx  = cur_q.ctx;
    wr_data.key  = cur_q.key;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      addr_q      <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && (state_q != B_WAIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == '1) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid_i) begin
            cur_q        <= pop_item_i;
            addr_q       <= pop_item_i.home[IW-1:0];
            probe_q      <= '0;
            res_ctx_q    <= '0;
            res_flag_q   <= 1'b0;
            res_status_q <= (pop_item_i.action == ACT_INSERT) ? ST_DUPLICATE : ST_MISS;
            state_q      <= pop_item_i.zero_key ? B_WAIT : B_READ;
          end
        end
        B_READ: begin
          state_q <= B_CHECK;
        end
        B_CHECK: begin
          if (match) begin
            if (cur_q.action == ACT_INSERT) begin
              res_status_q <= ST_DUPLICATE;
            end else begin
              res_status_q <= ST_HIT;
              res_ctx_q    <= rd_q.ctx;
              res_flag_q   <= rd_q.flag;
            end
            state_q <= B_WAIT;
          end else if (!rd_q.used) begin
            res_status_q <= (cur_q.action == ACT_INSERT) ? ST_INSERTED : ST_MISS;
            state_q      <= B_WAIT;
          end else if (probe_q == '1) begin
            res_status_q <= (cur_q.action == ACT_INSERT) ? ST_FULL : ST_MISS;
            state_q      <= B_WAIT;
          end else begin
            addr_q  <= addr_q + 1'b1;
            probe_q <= probe_q + 1'b1;
            state_q <= B_READ;
          end
        end
        B_WAIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_ctx_q    <= res_ctx_q;
            out_flag_q   <= res_flag_q;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
